[sv/disk_request_scheduler_macros.svh]
// Assertion macros for the disk request scheduler.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef DISK_REQUEST_SCHEDULER_MACROS_SVH
`define DISK_REQUEST_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define DRS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DRS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DRS_ASSERT(label, clk, rst_n, prop, msg)
`define DRS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[sv/drs_pkg.sv]
// Shared types and constants for the disk request scheduler.
// No dependencies.
`default_nettype none
package drs_pkg;
  localparam int QueueDepth = 16;
  localparam int BlockBits  = 16;
  localparam int TagBits    = 8;

  localparam logic [1:0] MODE_FCFS  = 2'd0;
  localparam logic [1:0] MODE_SSTF  = 2'd1;
  localparam logic [1:0] MODE_CSCAN = 2'd2;
  localparam logic [1:0] MODE_RSVD  = 2'd3;

  localparam logic [1:0] ST_ENQ   = 2'd0;
  localparam logic [1:0] ST_DISP  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic FUNC_ENQ  = 1'b0;
  localparam logic FUNC_DISP = 1'b1;

  typedef struct packed {
    logic                 func;
    logic [BlockBits-1:0] block;
    logic                 is_write;
    logic [TagBits-1:0]   tag;
  } drs_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [BlockBits-1:0] out_block;
    logic                 out_is_write;
    logic [TagBits-1:0]   out_tag;
    logic [BlockBits-1:0] seek_distance;
    logic [31:0]          total_distance;
    logic [4:0]           queue_count;
  } drs_out_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic       load;    // append at the tail cell
    logic       remove;  // drop the picked cell and close the gap
  } drs_ctl_t;
endpackage
`default_nettype wire

[sv/drs_cell.sv]
// One queue slot of the scheduler: holds a request and shifts toward the head.
// Depends on drs_pkg.
`default_nettype none
module drs_cell import drs_pkg::*; #(
  parameter int BLOCK_BITS = BlockBits,
  parameter int TAG_BITS   = TagBits
) (
  input  wire logic                  clk,
  input  wire drs_ctl_t              ctl,
  input  wire logic                  is_tail,  // slot at entry_count
  input  wire logic                  shift,    // slot at or above the picked one
  input  wire logic [BLOCK_BITS-1:0] new_block,
  input  wire logic                  new_write,
  input  wire logic [TAG_BITS-1:0]   new_tag,
  input  wire logic [BLOCK_BITS-1:0] up_block,  // neighbor above
  input  wire logic                  up_write,
  input  wire logic [TAG_BITS-1:0]   up_tag,
  output logic      [BLOCK_BITS-1:0] blk_r,
  output logic                       wr_r,
  output logic      [TAG_BITS-1:0]   tag_r
);
  logic [BLOCK_BITS-1:0] blk_nxt;
  logic                  wr_nxt;
  logic [TAG_BITS-1:0]   tag_nxt;

  always_comb begin
    blk_nxt = blk_r;
    wr_nxt  = wr_r;
    tag_nxt = tag_r;
    if (ctl.load && is_tail) begin
      blk_nxt = new_block;
      wr_nxt  = new_write;
      tag_nxt = new_tag;
    end else if (ctl.remove && shift) begin
      blk_nxt = up_block;
      wr_nxt  = up_write;
      tag_nxt = up_tag;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    wr_r  <= wr_nxt;
    tag_r <= tag_nxt;
  end
endmodule
`default_nettype wire

[sv/disk_request_scheduler.sv]
// Disk request scheduler.
// Channels: in_valid/in_stall/in_data carries one command beat (enqueue or
// dispatch); out_valid/out_stall/out_data returns exactly one result beat per
// command. cfg_valid/cfg_ready/cfg_data writes the scheduling mode (0 FCFS,
// 1 shortest seek, 2 circular scan, 3 acts as FCFS).
// Requests sit in a row of cells in arrival order. An enqueue, a dropped
// enqueue or a dispatch on an empty queue goes from accept through S_SCAN
// and S_OUT to the result register. A dispatch scans the cells one per cycle
// with a single compare unit, then passes through S_DONE, which it re-enters
// when circular scan wraps to the lowest block; removing the picked
// cell shifts all the upper cells down by one together.
// One command is in flight at a time; in_stall is high while busy or while a
// result waits in the output register. A stalled result holds out_data.
// Reset (synchronous, rst_n low) empties the queue, sets head and total to
// zero and the mode to FCFS; no clearing pass is needed.
// Dispatch results carry the picked request, |block - old head| and the
// saturating total; other statuses carry zeros there but the current total.
`default_nettype none
module disk_request_scheduler import drs_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire drs_in_t    in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output drs_out_t        out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_data
);
`include "disk_request_scheduler_macros.svh"
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [1:0]           mode_r;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [BlockBits-1:0] head_r, head_nxt;
  logic [31:0]          total_r, total_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [IW-1:0]        best_r, best_nxt;
  logic [BlockBits-1:0] bd_r, bd_nxt;
  logic                 found_r, found_nxt;
  logic [IW-1:0]        low_r, low_nxt;
  logic [BlockBits-1:0] lowb_r, lowb_nxt;
  logic                 ov_r, ov_nxt;
  drs_out_t             res_r, res_nxt;
  drs_in_t              cmd_r;
  drs_ctl_t             ctl;

  logic [BlockBits-1:0] c_blk [QUEUE_DEPTH];
  logic                 c_wr  [QUEUE_DEPTH];
  logic [TagBits-1:0]   c_tag [QUEUE_DEPTH];

  logic accept;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE) || ov_r;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = res_r;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [BlockBits-1:0] ub;
    logic                 uw;
    logic [TagBits-1:0]   ut;
    if (g == QUEUE_DEPTH - 1) begin : g_top
      assign ub = c_blk[g];
      assign uw = c_wr[g];
      assign ut = c_tag[g];
    end else begin : g_mid
      assign ub = c_blk[g+1];
      assign uw = c_wr[g+1];
      assign ut = c_tag[g+1];
    end
    drs_cell #(
      .BLOCK_BITS(BlockBits),
      .TAG_BITS  (TagBits)
    ) u_cell (
      .clk(clk), .ctl(ctl),
      .is_tail(cnt_r == CW'(g)),
      .shift(IW'(g) >= best_r),
      .new_block(cmd_r.block), .new_write(cmd_r.is_write), .new_tag(cmd_r.tag),
      .up_block(ub), .up_write(uw), .up_tag(ut),
      .blk_r(c_blk[g]), .wr_r(c_wr[g]), .tag_r(c_tag[g])
    );
  end

  // scan compare on the cell at idx_r
  logic [BlockBits-1:0] sb, sgap, pb;
  logic                 last;
  logic [32:0]          sum;
  assign sb   = c_blk[idx_r];
  assign sgap = (sb > head_r) ? sb - head_r : head_r - sb;
  assign last = (CW'(idx_r) + CW'(1)) >= cnt_r;
  assign pb   = c_blk[best_r];
  logic [BlockBits-1:0] pgap;
  assign pgap = (pb > head_r) ? pb - head_r : head_r - pb;
  assign sum  = {1'b0, total_r} + 33'(pgap);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    head_nxt  = head_r;
    total_nxt = total_r;
    idx_nxt   = idx_r;
    best_nxt  = best_r;
    bd_nxt    = bd_r;
    found_nxt = found_r;
    low_nxt   = low_r;
    lowb_nxt  = lowb_r;
    ov_nxt    = ov_r && out_stall;
    res_nxt   = res_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt   = '0;
          best_nxt  = '0;
          found_nxt = 1'b0;
          low_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        res_nxt = '0;
        res_nxt.total_distance = total_r;
        res_nxt.queue_count    = 5'(cnt_r);
        if (cmd_r.func == FUNC_ENQ) begin
          if (cnt_r == CW'(QUEUE_DEPTH)) begin
            res_nxt.status = ST_FULL;
          end else begin
            ctl.load = 1'b1;
            cnt_nxt  = cnt_r + CW'(1);
            res_nxt.status = ST_ENQ;
            res_nxt.queue_count = 5'(cnt_r + CW'(1));
          end
          state_nxt = S_OUT;
        end else if (cnt_r == '0) begin
          res_nxt.status = ST_EMPTY;
          state_nxt = S_OUT;
        end else begin
          unique case (mode_r)
            MODE_SSTF: begin
              if (idx_r == '0 || sgap < bd_r) begin
                bd_nxt = sgap;
                best_nxt = idx_r;
              end
            end
            MODE_CSCAN: begin
              if (sb > head_r && (!found_r || sgap < bd_r)) begin
                found_nxt = 1'b1;
                bd_nxt = sgap;
                best_nxt = idx_r;
              end
              if (idx_r == '0 || sb < lowb_r) begin
                low_nxt = idx_r;
                lowb_nxt = sb;
              end
            end
            default: ;
          endcase
          idx_nxt = idx_r + IW'(1);
          if (last) state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (mode_r == MODE_CSCAN && !found_r) begin
          best_nxt = low_r;
        end
        state_nxt = S_OUT;
        // stay in S_DONE while CSCAN falls back to the low entry, until best_r holds it
        if (mode_r == MODE_CSCAN && !found_r && best_r != low_r) state_nxt = S_DONE;
        else begin
          res_nxt.status       = ST_DISP;
          res_nxt.out_block    = pb;
          res_nxt.out_is_write = c_wr[best_r];
          res_nxt.out_tag      = c_tag[best_r];
          res_nxt.seek_distance = pgap;
          total_nxt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          res_nxt.total_distance = total_nxt;
          head_nxt = pb;
          cnt_nxt  = cnt_r - CW'(1);
          res_nxt.queue_count = 5'(cnt_r - CW'(1));
          ctl.remove = 1'b1;
        end
      end
      S_OUT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= MODE_FCFS;
      cnt_r   <= '0;
      head_r  <= '0;
      total_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      head_r  <= head_nxt;
      total_r <= total_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid && cfg_ready) mode_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) cmd_r <= in_data;
    idx_r   <= idx_nxt;
    best_r  <= best_nxt;
    bd_r    <= bd_nxt;
    found_r <= found_nxt;
    low_r   <= low_nxt;
    lowb_r  <= lowb_nxt;
    res_r   <= res_nxt;
  end

  `DRS_ASSERT(a_cnt_range, clk, rst_n, cnt_r <= CW'(QUEUE_DEPTH), "queue count overflow")
  `DRS_ASSERT(a_no_accept_busy, clk, rst_n, (state_r != S_IDLE) |-> !accept, "accept while busy")
  `DRS_ASSERT(a_total_mono, clk, rst_n, $past(rst_n) |-> total_r >= $past(total_r), "total decreased")
  `DRS_ASSERT(a_one_ctl, clk, rst_n, !(ctl.load && ctl.remove), "load and remove together")
endmodule
`default_nettype wire
